>>> design/srsd_pkg.sv
// ----------------------------------------------------------------------------
// srsd_pkg
// Shared types, constants and the segment table for the sensor reading
// seven-segment display unit.
// ----------------------------------------------------------------------------
package srsd_pkg;

  localparam int unsigned FrameBytesDef = 9;
  localparam int unsigned NumDigitsDef  = 4;

  localparam int unsigned FallbackW     = 14;
  localparam int unsigned ValueW        = 16;
  localparam int unsigned PaddrW        = 3;
  localparam int unsigned PdataW        = 32;

  localparam logic [7:0]           ReplyTag      = 8'd134;
  localparam logic [FallbackW-1:0] FallbackReset = 14'd9999;

  // reciprocal of ten, exact for every 16-bit value: q = (v * 52429) >> 19
  localparam logic [ValueW-1:0] RecipTen   = 16'd52429;
  localparam int unsigned       RecipShift = 19;

  // op codes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_SCAN = 1'b1;

  // register index (paddr[2])
  localparam logic REG_FALLBACK = 1'b0;

  typedef struct packed {
    logic       op;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [5:0] segments_main;
    logic       segment_extra;
    logic [3:0] digit_select_n;
    logic [1:0] digit_position;
  } out_item_t;

  typedef struct packed {
    logic byte_load;
    logic scan_load;
    logic conv_init;
    logic conv_step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic frame_end;
    logic conv_last;
  } ctrl_stat_t;

  function automatic logic [5:0] seg_main(input logic [3:0] d);
    logic [5:0] s;
    case (d)
      4'd0:    s = 6'h1F;
      4'd1:    s = 6'h10;
      4'd2:    s = 6'h2E;
      4'd3:    s = 6'h3C;
      4'd4:    s = 6'h31;
      4'd5:    s = 6'h3D;
      4'd6:    s = 6'h3F;
      4'd7:    s = 6'h18;
      4'd8:    s = 6'h3F;
      4'd9:    s = 6'h3D;
      default: s = 6'h00;
    endcase
    return s;
  endfunction

endpackage

>>> design/srsd_ctrl.sv
// ----------------------------------------------------------------------------
// srsd_ctrl
// Sequencer: input handshake, output valid, and the digit conversion steps.
// ----------------------------------------------------------------------------
module srsd_ctrl
  import srsd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_op_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  ctrl_stat_t stat_i,
  output ctrl_cmd_t  cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_CONV = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       idle, out_free, accept;

  assign idle       = (state_q == ST_IDLE);
  assign out_free   = !out_valid_q || out_ready_i;
  // a reply byte never needs the output register
  assign in_ready_o = idle && ((in_op_i == OP_BYTE) || out_free);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o           = '0;
    cmd_o.byte_load = accept && (in_op_i == OP_BYTE);
    cmd_o.scan_load = accept && (in_op_i == OP_SCAN);
    cmd_o.conv_init = (state_q == ST_LOAD);
    cmd_o.conv_step = (state_q == ST_CONV);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_o.byte_load && stat_i.frame_end) state_d = ST_LOAD;
      end
      ST_LOAD: state_d = ST_CONV;
      ST_CONV: begin
        if (stat_i.conv_last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.scan_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

>>> design/srsd_dp.sv
// ----------------------------------------------------------------------------
// srsd_dp
// Datapath: reply frame capture, fallback register, divide-by-ten digit
// conversion, digit store, scan position and output register.
// ----------------------------------------------------------------------------
module srsd_dp
  import srsd_pkg::*;
#(
  parameter int unsigned FRAME_BYTES = FrameBytesDef,
  parameter int unsigned NUM_DIGITS  = NumDigitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  in_item_t             in_data_i,
  input  ctrl_cmd_t            cmd_i,
  output ctrl_stat_t           stat_o,
  input  logic                 cfg_we_i,
  input  logic [FallbackW-1:0] cfg_wdata_i,
  output logic [FallbackW-1:0] fallback_o,
  output out_item_t            out_data_o
);

  localparam int unsigned IdxW = $clog2(FRAME_BYTES);
  localparam int unsigned PosW = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
  localparam int unsigned LitW = $clog2(NUM_DIGITS + 1);
  localparam logic [IdxW-1:0] IdxLast = IdxW'(FRAME_BYTES - 1);
  localparam logic [PosW-1:0] PosLast = PosW'(NUM_DIGITS - 1);

  logic [IdxW-1:0]      byte_idx_q;
  logic                 reply_ok_q;
  logic [7:0]           rd_high_q, rd_low_q;
  logic [FallbackW-1:0] fallback_q;
  logic [ValueW-1:0]    val_q;
  logic [PosW-1:0]      step_q;
  logic [3:0]           digit_q [NUM_DIGITS];
  logic [LitW-1:0]      lit_q;
  logic [PosW-1:0]      scan_q;
  out_item_t            out_q;

  logic [ValueW-1:0]    reading, load_val;
  logic [2*ValueW-1:0]  prod;
  logic [ValueW-1:0]    quot, quot10, rem_full;
  logic [3:0]           rem;

  assign stat_o.frame_end = (byte_idx_q == IdxLast);
  assign stat_o.conv_last = (step_q == PosLast);
  assign fallback_o       = fallback_q;
  assign out_data_o       = out_q;

  assign reading  = {rd_high_q, rd_low_q};
  assign load_val = (reply_ok_q && (reading != '0)) ? reading
                                                     : ValueW'(fallback_q);

  // one quotient digit per cycle
  assign prod     = val_q * RecipTen;
  assign quot     = ValueW'(prod >> RecipShift);
  assign quot10   = (quot << 3) + (quot << 1);
  assign rem_full = val_q - quot10;
  assign rem      = rem_full[3:0];

  // fallback register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fallback_q <= FallbackReset;
    end else if (cfg_we_i) begin
      fallback_q <= cfg_wdata_i;
    end
  end

  // frame capture
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_idx_q <= '0;
      reply_ok_q <= 1'b0;
      rd_high_q  <= '0;
      rd_low_q   <= '0;
    end else if (cmd_i.byte_load) begin
      if (byte_idx_q == IdxW'(1)) reply_ok_q <= (in_data_i.rx_byte == ReplyTag);
      if (byte_idx_q == IdxW'(2)) rd_high_q  <= in_data_i.rx_byte;
      if (byte_idx_q == IdxW'(3)) rd_low_q   <= in_data_i.rx_byte;
      byte_idx_q <= stat_o.frame_end ? '0 : byte_idx_q + 1'b1;
    end
  end

  // digit conversion, least significant first
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      lit_q  <= '0;
      for (int i = 0; i < NUM_DIGITS; i++) digit_q[i] <= '0;
    end else if (cmd_i.conv_init) begin
      step_q <= '0;
      lit_q  <= '0;
    end else if (cmd_i.conv_step) begin
      step_q <= stat_o.conv_last ? '0 : step_q + 1'b1;
      if (val_q != '0) begin
        digit_q[step_q] <= rem;
        lit_q           <= LitW'(step_q) + 1'b1;
      end else begin
        digit_q[step_q] <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.conv_init) begin
      val_q <= load_val;
    end else if (cmd_i.conv_step) begin
      val_q <= quot;
    end
  end

  // scan
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q <= '0;
    end else if (cmd_i.scan_load) begin
      scan_q <= (scan_q == PosLast) ? '0 : scan_q + 1'b1;
    end
  end

  out_item_t  out_d;
  logic [3:0] cur_digit;
  logic [31:0] pos_ext;

  assign cur_digit = digit_q[scan_q];
  assign pos_ext   = 32'(scan_q);

  always_comb begin
    out_d                = '0;
    out_d.digit_select_n = 4'hF;
    out_d.digit_position = pos_ext[1:0];
    if (LitW'(scan_q) < lit_q) begin
      out_d.segments_main = seg_main(cur_digit);
      out_d.segment_extra = (cur_digit != 4'd5) && (cur_digit != 4'd6);
    end
    for (int i = 0; i < 4; i++) begin
      if (pos_ext == 32'(i)) out_d.digit_select_n[i] = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_load) out_q <= out_d;
  end

endmodule

>>> design/sensor_reading_seven_segment_display_unit.sv
// ----------------------------------------------------------------------------
// sensor_reading_seven_segment_display_unit
// Sensor reply decoder and multiplexed seven-segment display driver.
// ----------------------------------------------------------------------------
// Each request is either a reply byte (op 0) or a scan tick (op 1). A reply
// byte gives no result; the last byte of a frame then holds off input
// while the shown value is loaded and split into decimal digits, one digit
// per cycle through a single multiply-by-reciprocal divide-by-ten unit. A
// scan tick gives one result from a registered output; a tick waits while
// an earlier result is still untaken, reply bytes do not. The fallback
// value lives at byte address 0 of the register port.
module sensor_reading_seven_segment_display_unit
  import srsd_pkg::*;
#(
  parameter int unsigned FRAME_BYTES = FrameBytesDef,
  parameter int unsigned NUM_DIGITS  = NumDigitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_item_t          in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_item_t         out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready
);

  ctrl_cmd_t            cmd;
  ctrl_stat_t           stat;
  logic                 cfg_we;
  logic [FallbackW-1:0] fallback;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_FALLBACK);
  assign prdata = (paddr[2] == REG_FALLBACK) ? PdataW'(fallback) : '0;

  srsd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_op_i     (in_data_i.op),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  srsd_dp #(
    .FRAME_BYTES (FRAME_BYTES),
    .NUM_DIGITS  (NUM_DIGITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (pwdata[FallbackW-1:0]),
    .fallback_o  (fallback),
    .out_data_o  (out_data_o)
  );

endmodule

>>> design/srsd_checker.sv
// ----------------------------------------------------------------------------
// srsd_checker
// Port-level checks for the display unit, bound to the top level.
// ----------------------------------------------------------------------------
module srsd_checker
  import srsd_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input in_item_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_data_o,
  input logic      pready
);

  // a result stays until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped or changed while stalled");

  // an accepted tick shows up next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_data_i.op == OP_SCAN) |=> out_valid_o)
    else $error("scan tick gave no result");

  // at most one digit enabled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $countones(~out_data_o.digit_select_n) <= 1)
    else $error("more than one digit enabled");

  // a blank digit has all segments off
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.segments_main == '0) |-> !out_data_o.segment_extra)
    else $error("blank digit with extra segment lit");

  assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind sensor_reading_seven_segment_display_unit srsd_checker u_srsd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o),
  .pready      (pready)
);

>>> tb/sensor_reading_seven_segment_display_unit_tb.sv
// ----------------------------------------------------------------------------
// sensor_reading_seven_segment_display_unit_tb
// Self-checking bench for the sensor reply decoder and digit scan driver.
// Reply frames and scan ticks go in as valid/ready requests. A local model
// of the frame decoder and digit split predicts each scan result, and every
// result is checked field by field. The fallback register is written and
// read back over the register port once the request side has drained.
// ----------------------------------------------------------------------------
module sensor_reading_seven_segment_display_unit_tb
  import srsd_pkg::*;
();

  localparam int unsigned FrameLen      = FrameBytesDef;
  localparam int unsigned Digits        = NumDigitsDef;
  localparam int unsigned TagPos        = 1;
  localparam int unsigned HighPos       = 2;
  localparam int unsigned LowPos        = 3;
  localparam int unsigned SettleCycles  = 16;
  localparam int unsigned StallLimit    = 4000;
  localparam int unsigned RandomItems   = 1750;
  localparam int unsigned ReconfigEvery = 250;
  localparam int unsigned MaxPrinted    = 50;

  localparam logic [PaddrW-1:0] FallbackAddr = {REG_FALLBACK, 2'b00};

  // segment lines per decimal digit, digit 0 in the low six bits
  localparam logic [59:0] SegTable = {6'h3D, 6'h3F, 6'h18, 6'h3F, 6'h3D,
                                      6'h31, 6'h3C, 6'h2E, 6'h10, 6'h1F};

  typedef enum logic [1:0] {
    StallNone,
    StallLight,
    StallPeriodic,
    StallHeavy
  } stall_mode_e;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid;
  logic              in_ready;
  in_item_t          in_data;
  logic              out_valid;
  logic              out_ready;
  out_item_t         out_data;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PaddrW-1:0] paddr;
  logic [PdataW-1:0] pwdata;
  logic [PdataW-1:0] prdata;
  logic              pready;

  // display model state
  logic [FallbackW-1:0] fallback_shadow;
  int unsigned          frame_pos;
  logic                 tag_seen;
  logic [7:0]           reading_hi;
  logic [7:0]           reading_lo;
  logic [3:0]           digit_value [Digits];
  int unsigned          lit_digits;
  int unsigned          scan_idx;

  out_item_t   pending_scans [$];
  out_item_t   scan_want;
  int unsigned errors;
  int unsigned sent_items;
  int unsigned burst_left;
  int unsigned idle_cycles;
  int unsigned stall_tick;
  stall_mode_e stall_mode;

  sensor_reading_seven_segment_display_unit #(
    .FRAME_BYTES(FrameLen),
    .NUM_DIGITS (Digits)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------- model
  function automatic void load_shown_value(input int unsigned v);
    lit_digits = 0;
    for (int k = 0; k < Digits; k++) begin
      if (v > 0) begin
        digit_value[k] = 4'(v % 10);
        lit_digits     = k + 1;
        v              = v / 10;
      end else begin
        digit_value[k] = 4'd0;
      end
    end
  endfunction

  function automatic void apply_reply_byte(input logic [7:0] b);
    int unsigned reading;
    if (frame_pos == TagPos) begin
      tag_seen = (b == ReplyTag);
    end else if (frame_pos == HighPos) begin
      reading_hi = b;
    end else if (frame_pos == LowPos) begin
      reading_lo = b;
    end
    if (frame_pos + 1 >= FrameLen) begin
      reading = {reading_hi, reading_lo};
      load_shown_value((tag_seen && reading != 0) ? reading : int'(fallback_shadow));
      frame_pos = 0;
    end else begin
      frame_pos++;
    end
  endfunction

  function automatic out_item_t next_scan_output();
    out_item_t  r;
    logic [3:0] d;
    r                = '0;
    r.digit_select_n = 4'hF;
    if (scan_idx < lit_digits) begin
      d               = digit_value[scan_idx];
      r.segments_main = SegTable[int'(d) * 6 +: 6];
      r.segment_extra = !(d == 4'd5 || d == 4'd6);
    end
    if (scan_idx < 4) r.digit_select_n[scan_idx] = 1'b0;
    r.digit_position = 2'(scan_idx);
    scan_idx = (scan_idx + 1 >= Digits) ? 0 : scan_idx + 1;
    return r;
  endfunction

  // ------------------------------------------------------------- checking
  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (errors < MaxPrinted) begin
      $display("[%0t] mismatch %s: got 0x%0h expected 0x%0h", $time, what, got, want);
    end
    errors++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      if (pending_scans.size() == 0) begin
        report_mismatch("unexpected result", out_data, 0);
      end else begin
        scan_want = pending_scans.pop_front();
        if (out_data.segments_main !== scan_want.segments_main)
          report_mismatch("segments_main", out_data.segments_main, scan_want.segments_main);
        if (out_data.segment_extra !== scan_want.segment_extra)
          report_mismatch("segment_extra", out_data.segment_extra, scan_want.segment_extra);
        if (out_data.digit_select_n !== scan_want.digit_select_n)
          report_mismatch("digit_select_n", out_data.digit_select_n,
                          scan_want.digit_select_n);
        if (out_data.digit_position !== scan_want.digit_position)
          report_mismatch("digit_position", out_data.digit_position,
                          scan_want.digit_position);
      end
    end
  end

  // result side backpressure under a randomly chosen stall mode
  always @(posedge clk_i) begin
    stall_tick++;
    if (stall_tick % 48 == 0) stall_mode = stall_mode_e'($urandom_range(0, 3));
    case (stall_mode)
      StallNone:     out_ready <= 1'b1;
      StallLight:    out_ready <= ($urandom_range(0, 9) < 7);
      StallPeriodic: out_ready <= (stall_tick % 8 == 0);
      default:       out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= StallLimit) begin
        $display("[%0t] watchdog: no progress for %0d cycles", $time, StallLimit);
        $display("== FAIL ==");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // ------------------------------------------------------------- stimulus
  task automatic send_request(input in_item_t req);
    int unsigned gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        burst_left = $urandom_range(40, 120);
        gap        = 0;
      end else begin
        burst_left = $urandom_range(1, 24);
        gap        = $urandom_range(0, 6);
      end
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk_i); while (!in_ready);
    burst_left--;
    sent_items++;
    if (req.op == OP_SCAN) begin
      pending_scans.push_back(next_scan_output());
    end else begin
      apply_reply_byte(req.rx_byte);
    end
  endtask

  task automatic send_byte(input logic [7:0] b);
    in_item_t req;
    req.op      = OP_BYTE;
    req.rx_byte = b;
    send_request(req);
  endtask

  task automatic send_scans(input int unsigned n);
    in_item_t req;
    req.op = OP_SCAN;
    repeat (n) begin
      req.rx_byte = 8'($urandom_range(0, 255));
      send_request(req);
    end
  endtask

  // completes the frame in progress; a frame that starts aligned is a full one
  task automatic send_frame(input logic [15:0] reading, input bit tag_good);
    logic [7:0] b;
    do begin
      if (frame_pos == TagPos) begin
        b = tag_good ? ReplyTag : 8'($urandom_range(0, 255));
      end else if (frame_pos == HighPos) begin
        b = reading[15:8];
      end else if (frame_pos == LowPos) begin
        b = reading[7:0];
      end else begin
        b = 8'($urandom_range(0, 255));
      end
      send_byte(b);
      if (frame_pos != 0 && $urandom_range(0, 3) == 0) send_scans($urandom_range(1, 2));
    end while (frame_pos != 0);
  endtask

  // idle the request side until every scan result is back and the digit
  // split of a just-closed frame has settled
  task automatic drain_requests();
    in_valid <= 1'b0;
    while (pending_scans.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // write followed by a back-to-back read of the same register
  task automatic cfg_write_fallback(input logic [PdataW-1:0] word);
    logic [PdataW-1:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= FallbackAddr;
    pwdata  <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    fallback_shadow = word[FallbackW-1:0];
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== PdataW'(fallback_shadow)) report_mismatch("fallback readback", got,
                                                           fallback_shadow);
  endtask

  // --------------------------------------------------------------- tests
  task automatic test_blank_until_first_frame();
    send_scans(Digits + 1);
  endtask

  task automatic test_fallback_cases();
    // wrong tag, every bit high: reset fallback shows
    repeat (FrameLen) send_byte(8'hFF);
    send_scans(Digits);
    drain_requests();
    // fallback above 9999, zero reading with a good tag
    cfg_write_fallback('1);
    send_frame(16'h0000, 1'b1);
    send_scans(Digits);
  endtask

  task automatic test_random_traffic();
    int unsigned      first_item;
    int unsigned      next_cfg;
    int unsigned      cfg_count;
    int unsigned      pick;
    int unsigned      value;
    logic [15:0]      reading;
    first_item = sent_items;
    next_cfg   = sent_items + ReconfigEvery;
    cfg_count  = 0;
    while (sent_items - first_item < RandomItems) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        case ($urandom_range(0, 5))
          0:       reading = 16'd0;
          1:       reading = 16'($urandom_range(1, 9));
          2:       reading = 16'($urandom_range(10, 999));
          3:       reading = 16'($urandom_range(1000, 9999));
          4:       reading = 16'($urandom_range(10000, 65535));
          default: reading = 16'($urandom());
        endcase
        send_frame(reading, $urandom_range(0, 9) != 0);
        send_scans($urandom_range(1, 2 * Digits));
      end else if (pick < 87) begin
        // stray bytes knock the frame position off
        repeat ($urandom_range(1, 5)) send_byte(8'($urandom_range(0, 255)));
      end else begin
        send_scans($urandom_range(1, 12));
      end
      if (sent_items >= next_cfg) begin
        drain_requests();
        case (cfg_count)
          0:       value = 0;
          1:       value = 16383;
          2:       value = 1;
          3:       value = 10000;
          default: value = $urandom_range(0, 16383);
        endcase
        cfg_write_fallback(($urandom() & 32'hFFFF_C000) | value);
        cfg_count++;
        next_cfg = sent_items + ReconfigEvery;
      end
    end
  endtask

  initial begin
    rst_ni    = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;

    fallback_shadow = FallbackReset;
    frame_pos       = 0;
    tag_seen        = 1'b0;
    reading_hi      = '0;
    reading_lo      = '0;
    for (int k = 0; k < Digits; k++) digit_value[k] = 4'd0;
    lit_digits  = 0;
    scan_idx    = 0;
    errors      = 0;
    sent_items  = 0;
    burst_left  = 0;
    idle_cycles = 0;
    stall_tick  = 0;
    stall_mode  = StallNone;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_blank_until_first_frame();
    test_fallback_cases();
    test_random_traffic();

    drain_requests();
    if (errors == 0 && pending_scans.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/srsd_pkg.sv
design/srsd_ctrl.sv
design/srsd_dp.sv
design/sensor_reading_seven_segment_display_unit.sv
design/srsd_checker.sv
tb/sensor_reading_seven_segment_display_unit_tb.sv
